// ===== src/sif_pkg.sv =====
// Shared types, constants and the control store of the servo instruction framer.
// Depends on nothing; every other file imports it.
package sif_pkg;

    // Protocol constants
    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [7:0] INS_PING  = 8'h01;
    localparam logic [7:0] INS_READ  = 8'h02;
    localparam logic [7:0] INS_WRITE = 8'h03;
    localparam logic [7:0] ID_RESET  = 8'd1;

    // Request kinds
    localparam logic [1:0] OP_PING  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Write data clamp: the smaller of MAX_DATA and the four data fields
    localparam int unsigned MAX_DATA    = 4;
    localparam int unsigned DATA_FIELDS = 4;
    localparam int unsigned DATA_LIMIT  = (MAX_DATA < DATA_FIELDS) ? MAX_DATA : DATA_FIELDS;
    localparam int unsigned PARAM_SLOTS = DATA_FIELDS + 1;
    localparam int unsigned PW          = $clog2(PARAM_SLOTS + 1);

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] reg_address;
        logic [7:0] byte_count;
        logic [7:0] data_byte0;
        logic [7:0] data_byte1;
        logic [7:0] data_byte2;
        logic [7:0] data_byte3;
    } t_req;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_rsp;

    // Byte source of one step
    typedef enum logic [2:0] {
        SEL_HDR,
        SEL_ID,
        SEL_LEN,
        SEL_INS,
        SEL_PARAM,
        SEL_CHK
    } t_sel;

    // Jump condition of one step
    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_PARAM,
        COND_MORE
    } t_cond;

    typedef logic [2:0] t_step;

    localparam t_step STEP_INS   = 3'd4;
    localparam t_step STEP_PARAM = 3'd5;
    localparam t_step STEP_CHK   = 3'd6;

    typedef struct packed {
        t_sel  sel;
        logic  sum;
        logic  last;
        t_cond cond;
        t_step target;
    } t_ucode;

    // Sequencer to datapath
    typedef struct packed {
        logic  advance;
        t_sel  sel;
        logic  sum;
        logic  last;
    } t_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic no_param;
        logic more;
    } t_stat;

    // Control store: one word per step; the parameter step repeats for each parameter byte
    function automatic t_ucode sif_ucode(input t_step step);
        t_ucode w;
        w = '{sel: SEL_CHK, sum: 1'b0, last: 1'b1, cond: COND_NONE, target: STEP_CHK};
        unique case (step)
            3'd0: w = '{sel: SEL_HDR,   sum: 1'b0, last: 1'b0, cond: COND_NONE,
                        target: 3'd0};
            3'd1: w = '{sel: SEL_HDR,   sum: 1'b0, last: 1'b0, cond: COND_NONE,
                        target: 3'd0};
            3'd2: w = '{sel: SEL_ID,    sum: 1'b1, last: 1'b0, cond: COND_NONE,
                        target: 3'd0};
            3'd3: w = '{sel: SEL_LEN,   sum: 1'b1, last: 1'b0, cond: COND_NONE,
                        target: 3'd0};
            3'd4: w = '{sel: SEL_INS,   sum: 1'b1, last: 1'b0, cond: COND_NO_PARAM,
                        target: STEP_CHK};
            3'd5: w = '{sel: SEL_PARAM, sum: 1'b1, last: 1'b0, cond: COND_MORE,
                        target: STEP_PARAM};
            default: w = '{sel: SEL_CHK, sum: 1'b0, last: 1'b1, cond: COND_NONE,
                           target: STEP_CHK};
        endcase
        return w;
    endfunction

endpackage

// ===== src/sif_sequencer.sv =====
// Step counter and control store lookup with conditional jumps.
// Depends on sif_pkg.
module sif_sequencer
    import sif_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_ctrl o_ctrl
);

    logic   r_busy, n_busy;
    t_step  r_step, n_step;
    t_ucode w;
    logic   advance;
    logic   taken;

    always_comb begin
        w       = sif_ucode(r_step);
        advance = r_busy && i_out_free;
        taken   = ((w.cond == COND_NO_PARAM) && i_stat.no_param) ||
                  ((w.cond == COND_MORE) && i_stat.more);
        n_busy  = r_busy;
        n_step  = r_step;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (advance) begin
            if (w.last) begin
                n_busy = 1'b0;
            end else if (taken) begin
                n_step = w.target;
            end else begin
                n_step = r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_busy = r_busy;
    assign o_ctrl = '{advance: advance, sel: w.sel, sum: w.sum, last: w.last};

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= STEP_CHK))
        else $error("step counter out of program range");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && w.last) |=> !r_busy)
        else $error("sequencer still busy after checksum byte");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("packet started while another is in flight");
`endif

endmodule

// ===== src/sif_datapath.sv =====
// Servo ID register, request latch, parameter list, byte selection and running checksum.
// Depends on sif_pkg.
module sif_datapath
    import sif_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_load,
    input  t_req       i_req,
    input  t_ctrl      i_ctrl,
    output t_stat      o_stat,
    output t_rsp       o_rsp
);

    logic [7:0]    r_id;
    logic [7:0]    r_ins;
    logic [PW-1:0] r_np;
    logic [PW-1:0] r_idx;
    logic [7:0]    r_sum;
    logic [7:0]    r_param [PARAM_SLOTS];
    logic [PW-1:0] n_np;
    logic [7:0]    n_ins;
    logic [PW-1:0] wr_cnt;
    logic [7:0]    byte_sel;

    // Clamp the write count and build the parameter count
    always_comb begin
        wr_cnt = (i_req.byte_count > 8'(DATA_LIMIT)) ? PW'(DATA_LIMIT)
                                                     : i_req.byte_count[PW-1:0];
        unique case (i_req.op)
            OP_PING: begin
                n_np  = '0;
                n_ins = INS_PING;
            end
            OP_READ: begin
                n_np  = PW'(2);
                n_ins = INS_READ;
            end
            default: begin
                n_np  = wr_cnt + PW'(1);
                n_ins = INS_WRITE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id <= ID_RESET;
        end else if (i_cfg_we) begin
            r_id <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_np       <= n_np;
            r_ins      <= n_ins;
            r_idx      <= '0;
            r_sum      <= '0;
            r_param[0] <= i_req.reg_address;
            r_param[1] <= (i_req.op == OP_READ) ? i_req.byte_count : i_req.data_byte0;
            r_param[2] <= i_req.data_byte1;
            r_param[3] <= i_req.data_byte2;
            r_param[4] <= i_req.data_byte3;
        end else if (i_ctrl.advance) begin
            if (i_ctrl.sum) begin
                r_sum <= r_sum + byte_sel;
            end
            if (i_ctrl.sel == SEL_PARAM) begin
                r_idx <= r_idx + PW'(1);
            end
        end
    end

    always_comb begin
        unique case (i_ctrl.sel)
            SEL_HDR:   byte_sel = HDR_BYTE;
            SEL_ID:    byte_sel = r_id;
            SEL_LEN:   byte_sel = 8'(r_np) + 8'd2;
            SEL_INS:   byte_sel = r_ins;
            SEL_PARAM: byte_sel = r_param[r_idx];
            default:   byte_sel = ~r_sum;
        endcase
    end

    assign o_stat = '{no_param: (r_np == '0), more: (r_idx != (r_np - PW'(1)))};
    assign o_rsp  = '{tx_byte: byte_sel, last_byte: i_ctrl.last};

`ifndef NO_ASSERTIONS
    a_param_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.advance && (i_ctrl.sel == SEL_PARAM)) |-> (r_idx < r_np))
        else $error("parameter index beyond parameter count");
`endif

endmodule

// ===== src/servo_instruction_packet_framer.sv =====
// Top level of the servo instruction packet framer: handshakes and output register.
// Depends on sif_pkg, sif_sequencer and sif_datapath.
//
// Usage:
//   Request channel (i_valid / o_ready, payload i_req): one item is a ping, read or
//   write request. o_ready is high whenever no packet is being framed. An item with
//   the unused op code is taken and dropped without output.
//   Byte channel (o_valid / i_ready, payload o_rsp): one item per packet byte in bus
//   order, last_byte set on the checksum byte.
//   Configuration: i_cfg_we writes i_cfg_data into the servo ID at once; write it
//   only while no packet is in flight.
// Timing:
//   A taken request's first header byte leaves via the step register, then the output
//   register. With no stall one byte leaves per cycle, so a packet of N bytes (6 for
//   ping, 8 for read, 7 to 11 for write) is framed in full before the next request is
//   taken; the bound is the single microcode step counter that emits one byte per step.
//   A stalled receiver holds the output register and freezes the step counter; the
//   next request is taken while the checksum byte still waits in the output register.
// Reset:
//   Synchronous, active low: the sequencer goes idle, the output register empties
//   and the servo ID returns to 1.
module servo_instruction_packet_framer
    import sif_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_req       i_req,
    output logic       o_valid,
    input  logic       i_ready,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    logic  busy;
    logic  accept;
    logic  start;
    logic  out_free;
    t_ctrl ctrl;
    t_stat stat;
    t_rsp  rsp_next;
    logic  r_out_valid;
    t_rsp  r_out;

    // Take a request only while idle; unused op codes never start the program
    assign o_ready  = !busy;
    assign accept   = i_valid && o_ready;
    assign start    = accept && ((i_req.op == OP_PING) || (i_req.op == OP_READ) ||
                                 (i_req.op == OP_WRITE));
    // The sequencer may advance when the output register is empty or draining
    assign out_free = !r_out_valid || i_ready;

    sif_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_busy     (busy),
        .o_ctrl     (ctrl)
    );

    sif_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_load     (accept),
        .i_req      (i_req),
        .i_ctrl     (ctrl),
        .o_stat     (stat),
        .o_rsp      (rsp_next)
    );

    // Output register: load on every step, hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.advance) begin
            r_out <= rsp_next;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

`ifndef NO_ASSERTIONS
    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.advance |=> r_out_valid)
        else $error("emitted byte lost from output register");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.advance && ctrl.last) |=> o_ready)
        else $error("not ready for a new item after checksum byte");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench of servo_instruction_packet_framer: a directed request table, then random
// requests, with every packet byte checked against typed-in bytes or a local packet predictor.
// Depends on sif_pkg and the framer RTL.
module tb;
    import sif_pkg::*;

    // Op code with no package name: the framer takes it and drops it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles to hold after the last expected byte before touching the servo ID.
    // The longest packet is 11 bytes, so this covers a dropped request still in flight.
    localparam int DRAIN_CYCLES = 16;
    localparam int N_RANDOM     = 180;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    // One row of the directed table: a request or a servo ID write.
    // Where has_gold is set, gold holds the packet bytes right-aligned, first byte highest.
    typedef struct {
        t_row_kind   kind;
        logic [7:0]  cfg_value;
        t_req        req;
        bit          has_gold;
        int          gold_len;
        logic [87:0] gold;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_req       i_req;
    logic       o_valid;
    logic       i_ready;
    t_rsp       o_rsp;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;

    // Bytes still owed by the framer, oldest first.
    t_rsp        tx_expect_q[$];
    // Mirror of the servo ID register.
    logic [7:0]  id_mirror;
    int          req_taken;
    int          err_count;
    // High during the stretch where neither side idles.
    bit          calm;
    // Typed-in packet of the request now on the channel, if any.
    bit          cur_has_gold;
    int          cur_gold_len;
    logic [87:0] cur_gold;
    t_row        dir_rows[$];

    servo_instruction_packet_framer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Print one line per mismatch and count.
    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("tb: mismatch at %0t ns: %s, got %0h, want %0h", $time, what, got, want);
    endtask

    // Build the full instruction packet for one request and queue its bytes.
    // An unused op code produces no bytes.
    task automatic frame_packet(input t_req r, input logic [7:0] id);
        logic [7:0] body [0:7];
        logic [7:0] data [0:3];
        logic [7:0] sum;
        int         n_body;
        int         n_data;
        int         k;
        data[0] = r.data_byte0;
        data[1] = r.data_byte1;
        data[2] = r.data_byte2;
        data[3] = r.data_byte3;
        body[0] = id;
        n_body  = 0;
        case (r.op)
            OP_PING: begin
                body[1] = 8'd2;
                body[2] = INS_PING;
                n_body  = 3;
            end
            OP_READ: begin
                body[1] = 8'd4;
                body[2] = INS_READ;
                body[3] = r.reg_address;
                body[4] = r.byte_count;
                n_body  = 5;
            end
            OP_WRITE: begin
                // Clamp the data count to what the four data fields can carry.
                n_data  = (r.byte_count > DATA_LIMIT) ? int'(DATA_LIMIT) : int'(r.byte_count);
                body[1] = 8'(n_data + 3);
                body[2] = INS_WRITE;
                body[3] = r.reg_address;
                for (k = 0; k < n_data; k++) begin
                    body[4 + k] = data[k];
                end
                n_body = 4 + n_data;
            end
            default: n_body = 0;
        endcase
        if (n_body != 0) begin
            tx_expect_q.push_back(t_rsp'{tx_byte: HDR_BYTE, last_byte: 1'b0});
            tx_expect_q.push_back(t_rsp'{tx_byte: HDR_BYTE, last_byte: 1'b0});
            sum = 8'd0;
            for (k = 0; k < n_body; k++) begin
                sum = sum + body[k];
                tx_expect_q.push_back(t_rsp'{tx_byte: body[k], last_byte: 1'b0});
            end
            // Checksum is the inverted sum of ID through the last parameter.
            tx_expect_q.push_back(t_rsp'{tx_byte: ~sum, last_byte: 1'b1});
        end
    endtask

    // Sample both channels at the rising edge: predict on an accepted request, check on
    // an accepted byte. Outputs read here are the values from before the edge.
    always @(posedge i_clk) begin
        t_rsp want;
        int   k;
        if (!i_rst_n) begin
            id_mirror = ID_RESET;
        end else begin
            if (i_cfg_we) begin
                id_mirror = i_cfg_data;
            end
            if (i_valid && o_ready) begin
                if (cur_has_gold) begin
                    for (k = 0; k < cur_gold_len; k++) begin
                        tx_expect_q.push_back(t_rsp'{
                            tx_byte:   cur_gold[8 * (cur_gold_len - 1 - k) +: 8],
                            last_byte: (k == cur_gold_len - 1)});
                    end
                end else begin
                    frame_packet(i_req, id_mirror);
                end
                req_taken++;
            end
            if (o_valid && i_ready) begin
                if (tx_expect_q.size() == 0) begin
                    report_mismatch("byte with nothing pending", o_rsp.tx_byte, 0);
                end else begin
                    want = tx_expect_q.pop_front();
                    if (o_rsp.tx_byte !== want.tx_byte) begin
                        report_mismatch("tx_byte", o_rsp.tx_byte, want.tx_byte);
                    end
                    if (o_rsp.last_byte !== want.last_byte) begin
                        report_mismatch("last_byte", o_rsp.last_byte, want.last_byte);
                    end
                end
            end
        end
    end

    // Byte receiver: stall about one cycle in ten, never during the calm stretch.
    always @(negedge i_clk) begin
        i_ready <= calm || ($urandom_range(0, 99) >= 10);
    end

    // Offer one request and hold it until it is taken. Called at a falling edge; the
    // previous item's valid is either lowered for a gap or replaced by this item in place.
    task automatic send_req(input t_req r, input bit has_gold, input int glen,
                            input logic [87:0] gold);
        int taken0;
        if (!calm && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < 30);
        end
        cur_has_gold = has_gold;
        cur_gold_len = glen;
        cur_gold     = gold;
        i_req   <= r;
        i_valid <= 1'b1;
        taken0 = req_taken;
        do @(negedge i_clk); while (req_taken == taken0);
    endtask

    // Drop valid, wait for every owed byte, then hold off long enough for a dropped
    // request to clear the framer.
    task automatic drain();
        i_valid <= 1'b0;
        while (tx_expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write the servo ID with the framer idle.
    task automatic write_servo_id(input logic [7:0] value);
        drain();
        i_cfg_data <= value;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_row req_row(input logic [1:0] op, input logic [7:0] adr,
                                     input logic [7:0] cnt, input logic [31:0] data,
                                     input bit has_gold, input int glen,
                                     input logic [87:0] gold);
        t_row row;
        row.kind            = ROW_REQ;
        row.cfg_value       = 8'd0;
        row.req.op          = op;
        row.req.reg_address = adr;
        row.req.byte_count  = cnt;
        row.req.data_byte0  = data[31:24];
        row.req.data_byte1  = data[23:16];
        row.req.data_byte2  = data[15:8];
        row.req.data_byte3  = data[7:0];
        row.has_gold        = has_gold;
        row.gold_len        = glen;
        row.gold            = gold;
        return row;
    endfunction

    function automatic t_row cfg_row(input logic [7:0] value);
        t_row row;
        row          = req_row(OP_PING, 8'd0, 8'd0, 32'd0, 1'b0, 0, 88'd0);
        row.kind     = ROW_CFG;
        row.cfg_value = value;
        return row;
    endfunction

    initial begin
        t_req r;
        int   n;
        int   pick;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_req        = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = 8'd0;
        calm         = 1'b0;
        cur_has_gold = 1'b0;
        cur_gold_len = 0;
        cur_gold     = 88'd0;
        req_taken    = 0;
        err_count    = 0;
        id_mirror    = ID_RESET;

        // Directed table. Packets after reset (ID 1) and at the extremes are typed in.
        dir_rows.push_back(req_row(OP_PING,  8'h00, 8'h00, 32'h0000_0000, 1, 6,
                                   88'hFFFF_0102_01FB));
        dir_rows.push_back(req_row(OP_READ,  8'h00, 8'h00, 32'h0000_0000, 1, 8,
                                   88'hFFFF_0104_0200_00F8));
        dir_rows.push_back(req_row(OP_READ,  8'hFF, 8'hFF, 32'hFFFF_FFFF, 1, 8,
                                   88'hFFFF_0104_02FF_FFFA));
        // Write with zero bytes: data fields ignored, seven-byte packet.
        dir_rows.push_back(req_row(OP_WRITE, 8'h00, 8'h00, 32'hAA55_AA55, 1, 7,
                                   88'hFFFF_0103_0300_F8));
        // Write count far above the clamp.
        dir_rows.push_back(req_row(OP_WRITE, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1, 11,
                                   88'hFFFF_0107_03FF_FFFF_FFFF_F9));
        // Unused op code: taken, nothing sent.
        dir_rows.push_back(req_row(OP_UNUSED, 8'h12, 8'h03, 32'h1234_5678, 1, 0, 88'd0));
        dir_rows.push_back(req_row(OP_WRITE, 8'h10, 8'h01, 32'h1122_3344, 0, 0, 88'd0));
        dir_rows.push_back(req_row(OP_WRITE, 8'h20, 8'h02, 32'h5566_7788, 0, 0, 88'd0));
        dir_rows.push_back(req_row(OP_WRITE, 8'h30, 8'h03, 32'h99AA_BBCC, 0, 0, 88'd0));
        dir_rows.push_back(req_row(OP_WRITE, 8'h40, 8'h04, 32'hDDEE_F001, 0, 0, 88'd0));
        dir_rows.push_back(req_row(OP_WRITE, 8'h50, 8'h05, 32'h0F1E_2D3C, 0, 0, 88'd0));
        dir_rows.push_back(req_row(OP_READ,  8'h5A, 8'h01, 32'h0000_0000, 0, 0, 88'd0));
        dir_rows.push_back(req_row(OP_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 0, 0, 88'd0));
        dir_rows.push_back(req_row(OP_PING,  8'hFF, 8'hFF, 32'hFFFF_FFFF, 0, 0, 88'd0));
        // Broadcast ID, then the lowest ID.
        dir_rows.push_back(cfg_row(8'd254));
        dir_rows.push_back(req_row(OP_PING,  8'h00, 8'h00, 32'h0000_0000, 1, 6,
                                   88'hFFFF_FE02_01FE));
        dir_rows.push_back(req_row(OP_WRITE, 8'h80, 8'h04, 32'h0102_0408, 0, 0, 88'd0));
        dir_rows.push_back(req_row(OP_READ,  8'hA5, 8'h80, 32'h0000_0000, 0, 0, 88'd0));
        dir_rows.push_back(cfg_row(8'd0));
        dir_rows.push_back(req_row(OP_PING,  8'h00, 8'h00, 32'h0000_0000, 1, 6,
                                   88'hFFFF_0002_01FC));
        dir_rows.push_back(req_row(OP_READ,  8'h00, 8'h80, 32'h0000_0000, 0, 0, 88'd0));
        dir_rows.push_back(req_row(OP_WRITE, 8'h7F, 8'h03, 32'hFF00_FF00, 0, 0, 88'd0));

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_servo_id(dir_rows[i].cfg_value);
            end else begin
                send_req(dir_rows[i].req, dir_rows[i].has_gold, dir_rows[i].gold_len,
                         dir_rows[i].gold);
            end
        end

        // Random requests, mostly well-formed, with a new servo ID every few dozen.
        for (n = 0; n < N_RANDOM; n++) begin
            if (n % 45 == 0) begin
                if (n == 0) begin
                    write_servo_id(8'd254);
                end else if (n == 90) begin
                    write_servo_id(8'd0);
                end else begin
                    write_servo_id(8'($urandom_range(1, 253)));
                end
            end
            calm = (n >= 70 && n < 120);
            pick = $urandom_range(0, 99);
            r.reg_address = 8'($urandom_range(0, 255));
            r.data_byte0  = 8'($urandom_range(0, 255));
            r.data_byte1  = 8'($urandom_range(0, 255));
            r.data_byte2  = 8'($urandom_range(0, 255));
            r.data_byte3  = 8'($urandom_range(0, 255));
            r.byte_count  = 8'($urandom_range(0, 255));
            if (pick < 8) begin
                r.op = OP_UNUSED;
            end else if (pick < 25) begin
                r.op = OP_PING;
            end else if (pick < 50) begin
                r.op = OP_READ;
                if ($urandom_range(0, 1) == 0) begin
                    r.byte_count = 8'($urandom_range(0, 4));
                end
            end else begin
                r.op = OP_WRITE;
                // Keep most counts around the clamp so every data length shows up.
                if ($urandom_range(0, 99) < 70) begin
                    r.byte_count = 8'($urandom_range(0, 6));
                end
            end
            send_req(r, 1'b0, 0, 88'd0);
        end
        calm = 1'b0;

        drain();
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sif_pkg.sv
src/sif_sequencer.sv
src/sif_datapath.sv
src/servo_instruction_packet_framer.sv
tb/tb.sv
